// ===== src/vplr_pkg.sv =====
// Shared field widths, protocol constants and command codes of the VXLAN peer table.
package vplr_pkg;

	localparam int MAC_W   = 48;
	localparam int VNI_W   = 24;
	localparam int PORT_W  = 16;
	localparam int PROTO_W = 8;

	localparam logic [PROTO_W-1:0] UDP_PROTO        = 8'd17;
	localparam logic [PORT_W-1:0]  VXLAN_PORT_RESET = 16'd4789;

	localparam logic CMD_INGRESS = 1'b0;
	localparam logic CMD_EGRESS  = 1'b1;

	localparam logic VERDICT_DROP = 1'b0;
	localparam logic VERDICT_PASS = 1'b1;

endpackage

// ===== src/vplr_entry_ram.sv =====
// Simple dual-port entry memory with a registered read port.
module vplr_entry_ram
	import vplr_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// The read data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/vplr_head_table.sv =====
// Hash bucket head memory: maps a MAC hash to the newest entry of its chain.
module vplr_head_table
	import vplr_pkg::*;
#(
	parameter int IDX_W = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [MAC_W-1:0] rd_mac,
	output logic [IDX_W:0]   rd_data,
	input  logic             wr_en,
	input  logic [IDX_W:0]   wr_data,
	output logic             clearing
);

	localparam int BUCKETS = 1 << IDX_W;

	// Word layout: MSB set means the bucket is empty, the rest is an entry index.
	logic [IDX_W:0]   mem [BUCKETS];
	logic [IDX_W:0]   rdata_q;
	logic [IDX_W-1:0] bucket_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             clearing_q;
	logic [IDX_W-1:0] rd_bucket;

	function automatic logic [IDX_W-1:0] bucket_of(input logic [MAC_W-1:0] mac);
		logic [IDX_W-1:0] h;
		h = '0;
		for (int i = 0; i < MAC_W; i++) begin
			h[i % IDX_W] = h[i % IDX_W] ^ mac[i];
		end
		return h;
	endfunction

	assign rd_bucket = bucket_of(rd_mac);

	// After reset every bucket is swept to empty, one per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == {IDX_W{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_idx_q] <= {1'b1, {IDX_W{1'b0}}};
		end else if (wr_en) begin
			// A write always goes to the bucket of the last lookup.
			mem[bucket_q] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q  <= mem[rd_bucket];
			bucket_q <= rd_bucket;
		end
	end

	assign rd_data  = rdata_q;
	assign clearing = clearing_q;

endmodule

// ===== src/vxlan_peer_learn_rewrite.sv =====
// Top level of the VXLAN peer learning and UDP port rewrite table.
// One request is taken at a time. A packet that is not VXLAN, or an ingress
// packet with a zero inner source MAC, gives its result in the cycle after start.
// Any other request hashes the MAC into a bucket head memory and then walks
// that bucket's chain in the entry memory, one entry read per cycle, until it
// finds the MAC or the end of the chain; an empty bucket ends it at the head.
// The result appears on the outputs for one cycle with done high and cannot
// be held off; start may be raised again in that same cycle. After reset the
// block is busy while the bucket heads are cleared; vxlan_port may be written
// during that time.
module vxlan_peer_learn_rewrite
	import vplr_pkg::*;
#(
	parameter int TABLE_ENTRIES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [PORT_W-1:0]  cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic [PROTO_W-1:0] ip_protocol,
	input  logic [PORT_W-1:0]  udp_src_port,
	input  logic [PORT_W-1:0]  udp_dst_port,
	input  logic [VNI_W-1:0]   vni,
	input  logic [MAC_W-1:0]   inner_src_mac,
	input  logic [MAC_W-1:0]   inner_dst_mac,
	output logic               done,
	output logic               verdict,
	output logic [PORT_W-1:0]  out_src_port,
	output logic [PORT_W-1:0]  out_dst_port,
	output logic               rewritten
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

	typedef struct packed {
		logic              nxt_null;
		logic [IDX_W-1:0]  nxt;
		logic [MAC_W-1:0]  mac;
		logic [VNI_W-1:0]  vni;
		logic [PORT_W-1:0] port;
	} entry_t;

	typedef struct packed {
		logic             empty;
		logic [IDX_W-1:0] idx;
	} head_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_HEAD = 3'b010,
		ST_WALK = 3'b100
	} state_t;

	state_t            state_q;
	logic [PORT_W-1:0] vxlan_port_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  cur_idx_q;

	logic              cmd_q;
	logic [PORT_W-1:0] sport_q;
	logic [PORT_W-1:0] dport_q;
	logic [VNI_W-1:0]  vni_q;
	logic [MAC_W-1:0]  key_q;

	logic              done_q;
	logic              verdict_q;
	logic [PORT_W-1:0] out_src_port_q;
	logic [PORT_W-1:0] out_dst_port_q;
	logic              rewritten_q;

	logic              clearing;
	logic              accept;
	logic              is_vxlan;
	logic              zero_src;
	logic              go;
	logic [MAC_W-1:0]  key_in;
	logic [IDX_W:0]    head_rdata;
	head_t             hd;
	entry_t            ent;
	entry_t            ent_wdata;
	logic [$bits(entry_t)-1:0] ent_rdata;
	logic              ent_re;
	logic [IDX_W-1:0]  ent_raddr;
	logic              ent_we;
	logic [IDX_W-1:0]  ent_waddr;
	logic              head_we;
	logic              res;
	logic              res_hit;
	logic              learn;
	logic              room;
	logic              do_rewrite;

	assign busy     = clearing || (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign is_vxlan = (ip_protocol == UDP_PROTO) && (udp_dst_port == vxlan_port_q);
	assign zero_src = (cmd == CMD_INGRESS) && (inner_src_mac == '0);
	assign go       = is_vxlan && !zero_src;
	assign key_in   = (cmd == CMD_EGRESS) ? inner_dst_mac : inner_src_mac;

	vplr_head_table #(
		.IDX_W(IDX_W)
	) u_head (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept && go),
		.rd_mac   (key_in),
		.rd_data  (head_rdata),
		.wr_en    (head_we),
		.wr_data  ({1'b0, fill_q[IDX_W-1:0]}),
		.clearing (clearing)
	);

	vplr_entry_ram #(
		.DEPTH(TABLE_ENTRIES),
		.WIDTH($bits(entry_t))
	) u_entries (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.re    (ent_re),
		.raddr (ent_raddr),
		.rdata (ent_rdata)
	);

	assign hd  = head_t'(head_rdata);
	assign ent = entry_t'(ent_rdata);

	// Chain walk: the head gives the newest entry, each entry links to an older one.
	always_comb begin
		ent_re    = 1'b0;
		ent_raddr = cur_idx_q;
		res       = 1'b0;
		res_hit   = 1'b0;
		unique case (state_q)
			ST_HEAD: begin
				if (hd.empty) begin
					res = 1'b1;
				end else begin
					ent_re    = 1'b1;
					ent_raddr = hd.idx;
				end
			end
			ST_WALK: begin
				if (ent.mac == key_q) begin
					res     = 1'b1;
					res_hit = 1'b1;
				end else if (ent.nxt_null) begin
					res = 1'b1;
				end else begin
					ent_re    = 1'b1;
					ent_raddr = ent.nxt;
				end
			end
			default: begin
			end
		endcase
	end

	// A new ingress MAC goes to the next free slot, if any, and heads its bucket.
	always_comb begin
		learn      = res && (cmd_q == CMD_INGRESS);
		room       = fill_q < CNT_W'(TABLE_ENTRIES);
		ent_we     = learn && (res_hit || room);
		head_we    = learn && !res_hit && room;
		ent_waddr  = res_hit ? cur_idx_q : fill_q[IDX_W-1:0];
		ent_wdata.mac  = key_q;
		ent_wdata.vni  = vni_q;
		ent_wdata.port = sport_q;
		if (res_hit) begin
			ent_wdata.nxt_null = ent.nxt_null;
			ent_wdata.nxt      = ent.nxt;
		end else begin
			ent_wdata.nxt_null = hd.empty;
			ent_wdata.nxt      = hd.idx;
		end
		do_rewrite = res && res_hit && (cmd_q == CMD_EGRESS) && (ent.vni == vni_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			vxlan_port_q <= VXLAN_PORT_RESET;
			fill_q       <= '0;
			done_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				vxlan_port_q <= cfg_wdata;
			end
			if (head_we) begin
				fill_q <= fill_q + 1'b1;
			end
			done_q <= (accept && !go) || res;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && go) begin
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					state_q <= res ? ST_IDLE : ST_WALK;
				end
				ST_WALK: begin
					if (res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd;
			sport_q <= udp_src_port;
			dport_q <= udp_dst_port;
			vni_q   <= vni;
			key_q   <= key_in;
		end
		if (ent_re) begin
			cur_idx_q <= ent_raddr;
		end
		if (accept && !go) begin
			verdict_q      <= (is_vxlan && zero_src) ? VERDICT_DROP : VERDICT_PASS;
			out_src_port_q <= udp_src_port;
			out_dst_port_q <= udp_dst_port;
			rewritten_q    <= 1'b0;
		end else if (res) begin
			verdict_q      <= VERDICT_PASS;
			out_src_port_q <= do_rewrite ? vxlan_port_q : sport_q;
			out_dst_port_q <= do_rewrite ? ent.port : dport_q;
			rewritten_q    <= do_rewrite;
		end
	end

	assign done         = done_q;
	assign verdict      = verdict_q;
	assign out_src_port = out_src_port_q;
	assign out_dst_port = out_dst_port_q;
	assign rewritten    = rewritten_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_ENTRIES))
		else $error("fill count exceeds table size");

	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (CNT_W'(cur_idx_q) < fill_q))
		else $error("chain walk reached an unwritten entry");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> ($past(accept) || $past(state_q != ST_IDLE)))
		else $error("result strobe without a request");

	a_rewrite_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rewritten_q) |-> (verdict_q == VERDICT_PASS && out_src_port_q == vxlan_port_q))
		else $error("rewritten result with wrong verdict or source port");

	a_no_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (state_q == ST_IDLE && !head_we))
		else $error("table activity during bucket clearing");

endmodule
